// ===== rtl/tgrr_pkg.sv =====
package tgrr_pkg;

	// Number of heater zones and the width of a zone index
	localparam int ZONE_COUNT = 6;
	localparam int ZONE_W     = (ZONE_COUNT > 1) ? $clog2(ZONE_COUNT) : 1;

	typedef logic [ZONE_COUNT-1:0] zone_vec_t;
	typedef logic [ZONE_W-1:0]     zone_idx_t;

	// Result of one circular search
	typedef struct packed {
		logic      hit;
		zone_idx_t zone;
	} pick_t;

	// Circular search from start+1 for the first requesting zone, optionally
	// skipping one excluded zone. The start zone itself is checked last.
	function automatic pick_t find_zone(zone_idx_t start, zone_vec_t req,
			logic use_excl, zone_idx_t excl);
		pick_t           r;
		logic [ZONE_W:0] sum;
		zone_idx_t       z;
		r = '0;
		// walk from the far end so the nearest hit wins
		for (int k = ZONE_COUNT; k >= 1; k--) begin
			sum = {1'b0, start} + (ZONE_W+1)'(k);
			if (sum >= (ZONE_W+1)'(ZONE_COUNT)) begin
				sum = sum - (ZONE_W+1)'(ZONE_COUNT);
			end
			z = sum[ZONE_W-1:0];
			if (req[z] && !(use_excl && (z == excl))) begin
				r.hit  = 1'b1;
				r.zone = z;
			end
		end
		return r;
	endfunction

	// Index of the lowest set bit (zero when none)
	function automatic zone_idx_t lowest_zone(zone_vec_t v);
		zone_idx_t r;
		r = '0;
		for (int i = ZONE_COUNT - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = ZONE_W'(i);
			end
		end
		return r;
	endfunction

	// Index of the highest set bit (zero when none)
	function automatic zone_idx_t highest_zone(zone_vec_t v);
		zone_idx_t r;
		r = '0;
		for (int i = 0; i < ZONE_COUNT; i++) begin
			if (v[i]) begin
				r = ZONE_W'(i);
			end
		end
		return r;
	endfunction

endpackage

// ===== rtl/tgrr_ifs.sv =====
// Request channel: one request vector per transfer
interface tgrr_req_if;
	import tgrr_pkg::*;
	logic      valid;
	logic      ready;
	zone_vec_t request_vector;
	modport source (output valid, output request_vector, input ready);
	modport sink   (input valid, input request_vector, output ready);
endinterface

// Grant channel: one grant vector per transfer
interface tgrr_gnt_if;
	import tgrr_pkg::*;
	logic      valid;
	logic      ready;
	zone_vec_t grant_vector;
	modport source (output valid, output grant_vector, input ready);
	modport sink   (input valid, input grant_vector, output ready);
endinterface

// ===== rtl/two_grant_round_robin_zone_arbiter.sv =====
// Two-grant round-robin zone arbiter.
//
// Channels: req (sink) carries a request vector, one bit per heater zone;
// gnt (source) carries the grant vector with at most two bits set. Both use
// valid/ready; a transfer happens on a clock edge with both high.
//
// Pipeline: a taken request is held in the input register and its grant is
// registered in the output register. Throughput is one request per cycle while
// the receiver takes grants; an input register and an output register bound a
// single pass of two circular priority searches plus the last-served update.
//
// Reset (arst_n low): both last-served zone indices go to zero, no grant is
// held and both pipeline stages are empty.
//
// Receiver stall: the grant stays valid and stable in the output register;
// an empty input register still takes one more request, and ready is low
// while both registers are full. No request or grant is dropped or repeated.
module two_grant_round_robin_zone_arbiter (
	input  logic      clk,
	input  logic      arst_n,
	tgrr_req_if.sink  req,
	tgrr_gnt_if.source gnt
);
	import tgrr_pkg::*;

	logic      valid_s1;
	zone_vec_t req_s1;
	logic      valid_s2;
	zone_vec_t grant_s2;
	zone_idx_t low_q;
	zone_idx_t high_q;
	zone_vec_t next_grants;
	logic      adv_s1;
	logic      take_in;

	// Pipeline control
	assign adv_s1    = valid_s1 && (!valid_s2 || gnt.ready);
	assign req.ready = !valid_s1 || adv_s1;
	assign take_in   = req.valid && req.ready;

	// Grant selection
	tgrr_pick u_pick (
		.req       (req_s1),
		.low_zone  (low_q),
		.high_zone (high_q),
		.grants    (next_grants)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			req_s1 <= req.request_vector;
		end
	end

	// Output register and last-served pair
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			low_q    <= '0;
			high_q   <= '0;
		end else begin
			if (adv_s1) begin
				valid_s2 <= 1'b1;
				// hold the pair when nothing was granted
				if (next_grants != '0) begin
					low_q  <= lowest_zone(next_grants);
					high_q <= highest_zone(next_grants);
				end
			end else if (gnt.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			grant_s2 <= next_grants;
		end
	end

	assign gnt.valid        = valid_s2;
	assign gnt.grant_vector = grant_s2;

endmodule

// ===== rtl/tgrr_pick.sv =====
module tgrr_pick (
	input  tgrr_pkg::zone_vec_t req,
	input  tgrr_pkg::zone_idx_t low_zone,
	input  tgrr_pkg::zone_idx_t high_zone,
	output tgrr_pkg::zone_vec_t grants
);
	import tgrr_pkg::*;

	pick_t pick1;
	pick_t pick2;

	// Source 1 from the low index, never the high index;
	// source 2 from the high index, never what source 1 took
	always_comb begin
		pick1  = find_zone(low_zone, req, 1'b1, high_zone);
		pick2  = find_zone(high_zone, req, pick1.hit, pick1.zone);
		grants = '0;
		if (pick1.hit) begin
			grants[pick1.zone] = 1'b1;
		end
		if (pick2.hit) begin
			grants[pick2.zone] = 1'b1;
		end
	end

endmodule

// ===== tb/testbench.sv =====
module testbench;
	import tgrr_pkg::*;

	localparam int RANDOM_ITEMS = 1400;
	localparam int CALM_TAIL    = 200;
	localparam int QUIET_LIMIT  = 1000;

	// one directed request; fixed rows carry a grant typed in by hand
	typedef struct packed {
		zone_vec_t asked;
		logic      fixed;
		zone_vec_t want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n;

	tgrr_req_if req_ch ();
	tgrr_gnt_if gnt_ch ();

	two_grant_round_robin_zone_arbiter DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.gnt    (gnt_ch)
	);

	always #2 clk = ~clk;

	// directed plan, starting from reset (pair 0,0, nothing held)
	row_t plan [22] = '{
		'{6'h00, 1'b1, 6'h00},  // nothing requested
		'{6'h01, 1'b1, 6'h01},  // lone request at the high index
		'{6'h3F, 1'b0, 6'h00},
		'{6'h00, 1'b1, 6'h00},  // idle tick, pair held
		'{6'h3F, 1'b0, 6'h00},
		'{6'h20, 1'b0, 6'h00},
		'{6'h10, 1'b0, 6'h00},
		'{6'h08, 1'b0, 6'h00},
		'{6'h04, 1'b0, 6'h00},
		'{6'h02, 1'b0, 6'h00},
		'{6'h21, 1'b0, 6'h00},
		'{6'h3F, 1'b0, 6'h00},
		'{6'h3F, 1'b0, 6'h00},
		'{6'h3F, 1'b0, 6'h00},
		'{6'h2A, 1'b0, 6'h00},
		'{6'h15, 1'b0, 6'h00},
		'{6'h00, 1'b1, 6'h00},
		'{6'h3E, 1'b0, 6'h00},
		'{6'h1F, 1'b0, 6'h00},
		'{6'h33, 1'b0, 6'h00},
		'{6'h0C, 1'b0, 6'h00},
		'{6'h01, 1'b0, 6'h00}
	};

	// arbiter state as the predictor sees it
	int        served_lo   = 0;
	int        served_hi   = 0;
	zone_vec_t last_grants = '0;

	zone_vec_t pending_grants [$];
	int        errors       = 0;
	int        quiet_cycles = 0;
	bit        idling       = 1'b1;
	int        hold_left    = 0;

	// first requesting zone after start, wrapping, start itself last
	function automatic int circular_pick(int start, zone_vec_t asked, bit skip_en, int skip);
		int z;
		for (int k = 1; k <= ZONE_COUNT; k++) begin
			z = (start + k) % ZONE_COUNT;
			if (asked[z] && !(skip_en && z == skip)) begin
				return z;
			end
		end
		return -1;
	endfunction

	// grant vector for one request vector; advances the predictor state
	function automatic zone_vec_t next_grants(zone_vec_t asked);
		int        first;
		int        second;
		int        t;
		zone_vec_t g;
		// refresh the served pair from the previous grants
		if (last_grants != '0) begin
			first = -1;
			for (int i = 0; i < ZONE_COUNT; i++) begin
				if (last_grants[i]) begin
					if (first < 0) begin
						first = i;
					end
					served_hi = i;
				end
			end
			served_lo = first;
		end
		if (served_lo > served_hi) begin
			t         = served_lo;
			served_lo = served_hi;
			served_hi = t;
		end
		first  = circular_pick(served_lo, asked, 1'b1, served_hi);
		second = circular_pick(served_hi, asked, first >= 0, first);
		g = '0;
		if (first >= 0) begin
			g[first] = 1'b1;
		end
		if (second >= 0) begin
			g[second] = 1'b1;
		end
		last_grants = g;
		return g;
	endfunction

	// mix of sparse, dense and empty request patterns
	function automatic zone_vec_t random_request();
		zone_vec_t v;
		case ($urandom_range(0, 5))
			0: begin
				v = zone_vec_t'(1 << $urandom_range(0, ZONE_COUNT - 1));
			end
			1: begin
				v = zone_vec_t'((1 << $urandom_range(0, ZONE_COUNT - 1)) |
					(1 << $urandom_range(0, ZONE_COUNT - 1)));
			end
			2: begin
				v = $urandom_range(0, 1) ? '1 : '0;
			end
			3: begin
				v = zone_vec_t'($urandom & $urandom);
			end
			default: begin
				v = zone_vec_t'($urandom);
			end
		endcase
		return v;
	endfunction

	// one request transfer, with an optional idle burst before it
	task automatic send(zone_vec_t asked, logic fixed, zone_vec_t want);
		zone_vec_t g;
		if (idling && $urandom_range(0, 3) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		req_ch.valid          <= 1'b1;
		req_ch.request_vector <= asked;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		g = next_grants(asked);
		pending_grants.push_back(fixed ? want : g);
	endtask

	// hold off requests until every grant has come back
	task automatic drain();
		req_ch.valid <= 1'b0;
		while (pending_grants.size() != 0) @(posedge clk);
	endtask

	// grant side backpressure in bursts
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left--;
			gnt_ch.ready <= 1'b0;
		end else if (idling && $urandom_range(0, 5) == 0) begin
			hold_left = $urandom_range(0, 15);
			gnt_ch.ready <= 1'b0;
		end else begin
			gnt_ch.ready <= 1'b1;
		end
	end

	// grant check and activity watch
	always @(posedge clk) begin
		zone_vec_t want;
		if (arst_n && gnt_ch.valid && gnt_ch.ready) begin
			if (pending_grants.size() == 0) begin
				$display("%0t grant with none pending: expected none actual %b",
					$time, gnt_ch.grant_vector);
				errors++;
			end else begin
				want = pending_grants.pop_front();
				if (gnt_ch.grant_vector !== want) begin
					$display("%0t grant_vector mismatch: expected %b actual %b",
						$time, want, gnt_ch.grant_vector);
					errors++;
				end
			end
		end
		if ((req_ch.valid && req_ch.ready) || (gnt_ch.valid && gnt_ch.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
	end

	initial begin
		arst_n                = 1'b0;
		req_ch.valid          = 1'b0;
		req_ch.request_vector = '0;
		gnt_ch.ready          = 1'b0;
		fork
			begin
				repeat (3) @(posedge clk);
				arst_n <= 1'b1;
				@(posedge clk);
				foreach (plan[i]) begin
					send(plan[i].asked, plan[i].fixed, plan[i].want);
				end
				drain();
				for (int n = 0; n < RANDOM_ITEMS; n++) begin
					if (n == RANDOM_ITEMS / 2) begin
						drain();
					end
					if (n == RANDOM_ITEMS - CALM_TAIL) begin
						idling = 1'b0;
					end
					send(random_request(), 1'b0, '0);
				end
				drain();
				repeat (8) @(posedge clk);
			end
			begin
				while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
			end
		join_any
		if (quiet_cycles < QUIET_LIMIT && errors == 0) begin
			$display("two_grant_round_robin_zone_arbiter regression: pass");
		end else begin
			$display("two_grant_round_robin_zone_arbiter regression: fail");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/tgrr_pkg.sv
rtl/tgrr_ifs.sv
rtl/tgrr_pick.sv
rtl/two_grant_round_robin_zone_arbiter.sv
tb/testbench.sv
